// File: rtl/gbfr_pkg.sv
// Shared types, constants and range table for the GB18030 four-byte range codec.
package gbfr_pkg;

  localparam logic OP_ENCODE      = 1'b0;
  localparam logic OP_DECODE      = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ILLEGAL = 1'b1;

  localparam int CP_W        = 21;
  localparam int LIN_W       = 21;
  localparam int BYTE_W      = 8;
  localparam int RANGE_COUNT = 13;
  localparam int SPAN_IDX_W  = $clog2(RANGE_COUNT);

  localparam logic [BYTE_W-1:0] LEAD_BASE  = 8'h81;
  localparam logic [BYTE_W-1:0] LEAD_MAX   = 8'hfe;
  localparam logic [BYTE_W-1:0] TRAIL_BASE = 8'h30;
  localparam logic [BYTE_W-1:0] TRAIL_MAX  = 8'h39;

  localparam int TRAIL_RADIX = 8'h3a - 8'h30;
  localparam int LEAD_RADIX  = 8'hff - 8'h81;
  localparam int PAIR_RADIX  = LEAD_RADIX * TRAIL_RADIX;
  localparam int PAIR_W      = $clog2(PAIR_RADIX);

  // reciprocal multipliers, exact for any 21-bit dividend
  localparam int          PROD_W    = 43;
  localparam int unsigned RCP10     = 1677722;
  localparam int          RCP10_SH  = 24;
  localparam int unsigned RCP1260   = 3408705;
  localparam int          RCP1260_SH = 32;
  localparam int unsigned RCP12600  = 2726964;
  localparam int          RCP12600_SH = 35;
  localparam int          Q10_W     = 18;
  localparam int          Q1260_W   = 11;
  localparam int          Q12600_W  = 8;

  localparam logic [LIN_W-1:0] SPAN_LIN_LO [RANGE_COUNT] = '{
    21'h00334, 21'h02403, 21'h032ad, 21'h0396a, 21'h03de7, 21'h04159, 21'h0440a,
    21'h04629, 21'h04a63, 21'h0830e, 21'h094be, 21'h099e2, 21'h2e248};
  localparam logic [LIN_W-1:0] SPAN_LIN_HI [RANGE_COUNT] = '{
    21'h01ef1, 21'h02c40, 21'h035a9, 21'h03cde, 21'h03fbd, 21'h042cd, 21'h045c2,
    21'h048e7, 21'h082bc, 21'h093d4, 21'h098c3, 21'h099fb, 21'h12e247};
  localparam logic [CP_W-1:0] SPAN_CP_LO [RANGE_COUNT] = '{
    21'h00452, 21'h02643, 21'h0361b, 21'h03ce1, 21'h04160, 21'h044d7, 21'h0478e,
    21'h049b8, 21'h09fa6, 21'h0e865, 21'h0fa2a, 21'h0ffe6, 21'h10000};
  localparam logic [CP_W-1:0] SPAN_CP_HI [RANGE_COUNT] = '{
    21'h0200f, 21'h02e80, 21'h03917, 21'h04055, 21'h04336, 21'h0464b, 21'h04946,
    21'h04c76, 21'h0d7ff, 21'h0f92b, 21'h0fe2f, 21'h0ffff, 21'h10ffff};

  typedef logic [SPAN_IDX_W-1:0] span_idx_t;

  typedef struct packed {
    logic      hit;
    span_idx_t idx;
  } span_hit_t;

  typedef struct packed {
    logic              vld;
    logic              op;
    logic              ok;
    span_idx_t         idx;
    logic [CP_W-1:0]   cp;
    logic [PAIR_W-1:0] pair_hi;
    logic [PAIR_W-1:0] pair_lo;
  } s1_t;

  typedef struct packed {
    logic             vld;
    logic             op;
    logic             ok;
    span_idx_t        idx;
    logic [LIN_W-1:0] lin;
  } s2_t;

  typedef struct packed {
    logic                vld;
    logic                op;
    logic                ok;
    span_idx_t           idx;
    logic [LIN_W-1:0]    lin;
    logic [Q10_W-1:0]    q10;
    logic [Q1260_W-1:0]  q1260;
    logic [Q12600_W-1:0] q12600;
  } s3_t;

  typedef struct packed {
    logic              vld;
    logic              status;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } res_t;

  function automatic logic is_lead(input logic [BYTE_W-1:0] b);
    return (b >= LEAD_BASE) && (b <= LEAD_MAX);
  endfunction

  function automatic logic is_trail(input logic [BYTE_W-1:0] b);
    return (b >= TRAIL_BASE) && (b <= TRAIL_MAX);
  endfunction

  // by_lin selects the linear spans, otherwise the code point spans
  function automatic span_hit_t find_span(input logic [LIN_W-1:0] v, input logic by_lin);
    span_hit_t        r;
    logic [LIN_W-1:0] lo_v;
    logic [LIN_W-1:0] hi_v;
    r = '0;
    for (int i = RANGE_COUNT - 1; i >= 0; i--) begin
      lo_v = by_lin ? SPAN_LIN_LO[i] : SPAN_CP_LO[i];
      hi_v = by_lin ? SPAN_LIN_HI[i] : SPAN_CP_HI[i];
      if ((v >= lo_v) && (v <= hi_v)) begin
        r.hit = 1'b1;
        r.idx = SPAN_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/gbfr_classify.sv
// Stage 1: code point range search and byte checks with pair folding.
module gbfr_classify import gbfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic              op_i,
  input  logic [CP_W-1:0]   cp_i,
  input  logic [BYTE_W-1:0] b0_i,
  input  logic [BYTE_W-1:0] b1_i,
  input  logic [BYTE_W-1:0] b2_i,
  input  logic [BYTE_W-1:0] b3_i,
  output s1_t               s1_o
);

  s1_t       s1_r;
  s1_t       s1_nxt;
  span_hit_t hit;
  logic      bytes_ok;

  always_comb begin
    hit      = find_span(cp_i, 1'b0);
    bytes_ok = is_lead(b0_i) && is_trail(b1_i) && is_lead(b2_i) && is_trail(b3_i);
    s1_nxt.vld     = vld_i;
    s1_nxt.op      = op_i;
    s1_nxt.ok      = (op_i == OP_DECODE) ? bytes_ok : hit.hit;
    s1_nxt.idx     = hit.idx;
    s1_nxt.cp      = cp_i;
    s1_nxt.pair_hi = PAIR_W'(b0_i - LEAD_BASE) * PAIR_W'(TRAIL_RADIX)
                   + PAIR_W'(b1_i - TRAIL_BASE);
    s1_nxt.pair_lo = PAIR_W'(b2_i - LEAD_BASE) * PAIR_W'(TRAIL_RADIX)
                   + PAIR_W'(b3_i - TRAIL_BASE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_o = s1_r;

endmodule

// File: rtl/gbfr_linear.sv
// Stage 2: linear value from code point offset or from folded byte pairs.
module gbfr_linear import gbfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  s1_t  s1_i,
  output s2_t  s2_o
);

  s2_t s2_r;
  s2_t s2_nxt;

  always_comb begin
    s2_nxt.vld = s1_i.vld;
    s2_nxt.op  = s1_i.op;
    s2_nxt.ok  = s1_i.ok;
    s2_nxt.idx = s1_i.idx;
    if (s1_i.op == OP_DECODE) begin
      s2_nxt.lin = LIN_W'(s1_i.pair_hi) * LIN_W'(PAIR_RADIX) + LIN_W'(s1_i.pair_lo);
    end else begin
      s2_nxt.lin = s1_i.cp - SPAN_CP_LO[s1_i.idx] + SPAN_LIN_LO[s1_i.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_o = s2_r;

endmodule

// File: rtl/gbfr_divide.sv
// Stage 3: reciprocal quotients for encode and linear range search for decode.
module gbfr_divide import gbfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  s2_t  s2_i,
  output s3_t  s3_o
);

  s3_t              s3_r;
  s3_t              s3_nxt;
  span_hit_t        hit;
  logic [PROD_W-1:0] p10;
  logic [PROD_W-1:0] p1260;
  logic [PROD_W-1:0] p12600;

  always_comb begin
    hit    = find_span(s2_i.lin, 1'b1);
    p10    = PROD_W'(s2_i.lin) * PROD_W'(RCP10);
    p1260  = PROD_W'(s2_i.lin) * PROD_W'(RCP1260);
    p12600 = PROD_W'(s2_i.lin) * PROD_W'(RCP12600);
    s3_nxt.vld    = s2_i.vld;
    s3_nxt.op     = s2_i.op;
    s3_nxt.ok     = (s2_i.op == OP_DECODE) ? (s2_i.ok && hit.hit) : s2_i.ok;
    s3_nxt.idx    = hit.idx;
    s3_nxt.lin    = s2_i.lin;
    s3_nxt.q10    = p10[RCP10_SH +: Q10_W];
    s3_nxt.q1260  = p1260[RCP1260_SH +: Q1260_W];
    s3_nxt.q12600 = p12600[RCP12600_SH +: Q12600_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else begin
      s3_r <= s3_nxt;
    end
  end

  assign s3_o = s3_r;

endmodule

// File: rtl/gbfr_emit.sv
// Stage 4: byte digits for encode, code point for decode, result register.
module gbfr_emit import gbfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  s3_t  s3_i,
  output res_t res_o
);

  res_t               res_r;
  res_t               res_nxt;
  logic [LIN_W-1:0]   d_full;
  logic [Q10_W-1:0]   c_full;
  logic [Q1260_W-1:0] b_full;
  logic [CP_W-1:0]    cp_dec;
  logic               enc_ok;
  logic               dec_ok;

  always_comb begin
    d_full = s3_i.lin - LIN_W'(s3_i.q10) * LIN_W'(TRAIL_RADIX);
    c_full = s3_i.q10 - Q10_W'(s3_i.q1260) * Q10_W'(LEAD_RADIX);
    b_full = s3_i.q1260 - Q1260_W'(s3_i.q12600) * Q1260_W'(TRAIL_RADIX);
    cp_dec = s3_i.lin - SPAN_LIN_LO[s3_i.idx] + SPAN_CP_LO[s3_i.idx];
    enc_ok = s3_i.ok && (s3_i.op == OP_ENCODE);
    dec_ok = s3_i.ok && (s3_i.op == OP_DECODE);
    res_nxt.vld    = s3_i.vld;
    res_nxt.status = s3_i.ok ? STATUS_OK : STATUS_ILLEGAL;
    res_nxt.cp     = dec_ok ? cp_dec : '0;
    res_nxt.b0     = enc_ok ? LEAD_BASE + BYTE_W'(s3_i.q12600) : '0;
    res_nxt.b1     = enc_ok ? TRAIL_BASE + BYTE_W'(b_full[3:0]) : '0;
    res_nxt.b2     = enc_ok ? LEAD_BASE + BYTE_W'(c_full[6:0]) : '0;
    res_nxt.b3     = enc_ok ? TRAIL_BASE + BYTE_W'(d_full[3:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// File: rtl/gb18030_four_byte_range_codec_unit.sv
// Top level of the GB18030 four-byte range codec.
// An accepted start passes the s1, s2, s3 and result registers on its way to its out_valid beat.
// Throughput: one beat per cycle while busy is low, through four register stages (range search,
// linear value, reciprocal divide, digit split); out_valid cannot be stalled.
// Reset: synchronous, active low; clears all stage valid bits, busy is high
// during reset and for the cycle after it.
module gb18030_four_byte_range_codec_unit import gbfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [CP_W-1:0]   in_code_point,
  input  logic [BYTE_W-1:0] in_byte_0,
  input  logic [BYTE_W-1:0] in_byte_1,
  input  logic [BYTE_W-1:0] in_byte_2,
  input  logic [BYTE_W-1:0] in_byte_3,
  output logic              out_valid,
  output logic              out_status,
  output logic [CP_W-1:0]   out_code_point,
  output logic [BYTE_W-1:0] out_byte_0,
  output logic [BYTE_W-1:0] out_byte_1,
  output logic [BYTE_W-1:0] out_byte_2,
  output logic [BYTE_W-1:0] out_byte_3
);

  localparam int LATENCY = 4;

  logic busy_r;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r | ~rst_n;

  gbfr_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (start & ~busy),
    .op_i  (in_operation),
    .cp_i  (in_code_point),
    .b0_i  (in_byte_0),
    .b1_i  (in_byte_1),
    .b2_i  (in_byte_2),
    .b3_i  (in_byte_3),
    .s1_o  (s1)
  );

  gbfr_linear u_linear (
    .clk   (clk),
    .rst_n (rst_n),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  gbfr_divide u_divide (
    .clk   (clk),
    .rst_n (rst_n),
    .s2_i  (s2),
    .s3_o  (s3)
  );

  gbfr_emit u_emit (
    .clk   (clk),
    .rst_n (rst_n),
    .s3_i  (s3),
    .res_o (res)
  );

  assign out_valid      = res.vld;
  assign out_status     = res.status;
  assign out_code_point = res.cp;
  assign out_byte_0     = res.b0;
  assign out_byte_1     = res.b1;
  assign out_byte_2     = res.b2;
  assign out_byte_3     = res.b3;

  a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, LATENCY))
    else $error("result beat does not match accepted beat");

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_ILLEGAL) |->
      (out_code_point == '0 && out_byte_0 == '0 && out_byte_1 == '0 &&
       out_byte_2 == '0 && out_byte_3 == '0))
    else $error("illegal result carries payload");

  a_encode_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_OK && $past(in_operation, LATENCY) == OP_ENCODE) |->
      (out_byte_0 >= LEAD_BASE && out_byte_0 <= LEAD_MAX &&
       out_byte_1 >= TRAIL_BASE && out_byte_1 <= TRAIL_MAX &&
       out_byte_2 >= LEAD_BASE && out_byte_2 <= LEAD_MAX &&
       out_byte_3 >= TRAIL_BASE && out_byte_3 <= TRAIL_MAX &&
       out_code_point == '0))
    else $error("encoded bytes out of lead or trail range");

  a_decode_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_OK && $past(in_operation, LATENCY) == OP_DECODE) |->
      (out_code_point <= SPAN_CP_HI[RANGE_COUNT-1] && out_byte_0 == '0 &&
       out_byte_1 == '0 && out_byte_2 == '0 && out_byte_3 == '0))
    else $error("decoded code point out of range");

endmodule

// File: tb/gb18030_four_byte_range_codec_unit_tb.sv
// Self-checking testbench for the GB18030 four-byte range codec: directed table plus random beats.
`timescale 1ns / 1ps

module gb18030_four_byte_range_codec_unit_tb;
  import gbfr_pkg::*;

  localparam int N_RANDOM = 1200;
  localparam int N_QUIET  = 200;
  localparam int WATCHDOG = 400;
  localparam int N_RNG    = 13;

  localparam int unsigned LEAD_LO    = 8'h81;
  localparam int unsigned LEAD_HI    = 8'hfe;
  localparam int unsigned TRAIL_LO   = 8'h30;
  localparam int unsigned TRAIL_HI   = 8'h39;
  localparam int unsigned LEAD_SPAN  = 126;
  localparam int unsigned TRAIL_SPAN = 10;

  localparam int unsigned RNG_LIN_LO [N_RNG] = '{
    'h00334, 'h02403, 'h032ad, 'h0396a, 'h03de7, 'h04159, 'h0440a,
    'h04629, 'h04a63, 'h0830e, 'h094be, 'h099e2, 'h2e248};
  localparam int unsigned RNG_LIN_HI [N_RNG] = '{
    'h01ef1, 'h02c40, 'h035a9, 'h03cde, 'h03fbd, 'h042cd, 'h045c2,
    'h048e7, 'h082bc, 'h093d4, 'h098c3, 'h099fb, 'h12e247};
  localparam int unsigned RNG_CP_LO [N_RNG] = '{
    'h00452, 'h02643, 'h0361b, 'h03ce1, 'h04160, 'h044d7, 'h0478e,
    'h049b8, 'h09fa6, 'h0e865, 'h0fa2a, 'h0ffe6, 'h10000};
  localparam int unsigned RNG_CP_HI [N_RNG] = '{
    'h0200f, 'h02e80, 'h03917, 'h04055, 'h04336, 'h0464b, 'h04946,
    'h04c76, 'h0d7ff, 'h0f92b, 'h0fe2f, 'h0ffff, 'h10ffff};

  typedef struct packed {
    logic              status;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } conv_t;

  typedef struct packed {
    logic              op;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic              typed;
    conv_t             want;
  } stim_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_operation = OP_ENCODE;
  logic [CP_W-1:0]   in_code_point = '0;
  logic [BYTE_W-1:0] in_byte_0 = '0;
  logic [BYTE_W-1:0] in_byte_1 = '0;
  logic [BYTE_W-1:0] in_byte_2 = '0;
  logic [BYTE_W-1:0] in_byte_3 = '0;
  logic              out_valid;
  logic              out_status;
  logic [CP_W-1:0]   out_code_point;
  logic [BYTE_W-1:0] out_byte_0;
  logic [BYTE_W-1:0] out_byte_1;
  logic [BYTE_W-1:0] out_byte_2;
  logic [BYTE_W-1:0] out_byte_3;

  conv_t conv_due[$];
  stim_t dir_tab[$];
  int    n_err = 0;
  int    n_checked = 0;
  int    n_enc = 0;
  int    n_dec = 0;
  int    n_ill = 0;
  int    stall_cycles = 0;

  gb18030_four_byte_range_codec_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_code_point (in_code_point),
    .in_byte_0     (in_byte_0),
    .in_byte_1     (in_byte_1),
    .in_byte_2     (in_byte_2),
    .in_byte_3     (in_byte_3),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_code_point(out_code_point),
    .out_byte_0    (out_byte_0),
    .out_byte_1    (out_byte_1),
    .out_byte_2    (out_byte_2),
    .out_byte_3    (out_byte_3)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic conv_t gb_convert(input logic op, input logic [CP_W-1:0] cp,
                                       input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                                       input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3);
    conv_t       r;
    int unsigned lin;
    r = '0;
    r.status = STATUS_ILLEGAL;
    if (op == OP_ENCODE) begin
      for (int i = 0; i < N_RNG; i++) begin
        if (r.status == STATUS_ILLEGAL && cp >= RNG_CP_LO[i] && cp <= RNG_CP_HI[i]) begin
          lin = int'(cp) - RNG_CP_LO[i] + RNG_LIN_LO[i];
          r.b3 = BYTE_W'(TRAIL_LO + lin % TRAIL_SPAN);
          lin = lin / TRAIL_SPAN;
          r.b2 = BYTE_W'(LEAD_LO + lin % LEAD_SPAN);
          lin = lin / LEAD_SPAN;
          r.b1 = BYTE_W'(TRAIL_LO + lin % TRAIL_SPAN);
          lin = lin / TRAIL_SPAN;
          r.b0 = BYTE_W'(LEAD_LO + lin);
          r.status = STATUS_OK;
        end
      end
    end else if (b0 >= LEAD_LO && b0 <= LEAD_HI && b1 >= TRAIL_LO && b1 <= TRAIL_HI &&
                 b2 >= LEAD_LO && b2 <= LEAD_HI && b3 >= TRAIL_LO && b3 <= TRAIL_HI) begin
      lin = int'(b0) - LEAD_LO;
      lin = lin * TRAIL_SPAN + (int'(b1) - TRAIL_LO);
      lin = lin * LEAD_SPAN + (int'(b2) - LEAD_LO);
      lin = lin * TRAIL_SPAN + (int'(b3) - TRAIL_LO);
      for (int i = 0; i < N_RNG; i++) begin
        if (r.status == STATUS_ILLEGAL && lin >= RNG_LIN_LO[i] && lin <= RNG_LIN_HI[i]) begin
          r.cp = CP_W'(lin - RNG_LIN_LO[i] + RNG_CP_LO[i]);
          r.status = STATUS_OK;
        end
      end
    end
    return r;
  endfunction

  function automatic stim_t mk(input logic op, input int unsigned cp, input int unsigned b0,
                               input int unsigned b1, input int unsigned b2, input int unsigned b3);
    stim_t s;
    s = '0;
    s.op = op;
    s.cp = CP_W'(cp);
    s.b0 = BYTE_W'(b0);
    s.b1 = BYTE_W'(b1);
    s.b2 = BYTE_W'(b2);
    s.b3 = BYTE_W'(b3);
    return s;
  endfunction

  function automatic stim_t typed(input stim_t s, input logic st, input int unsigned cp,
                                  input int unsigned e0, input int unsigned e1,
                                  input int unsigned e2, input int unsigned e3);
    stim_t r;
    r = s;
    r.typed = 1'b1;
    r.want.status = st;
    r.want.cp = CP_W'(cp);
    r.want.b0 = BYTE_W'(e0);
    r.want.b1 = BYTE_W'(e1);
    r.want.b2 = BYTE_W'(e2);
    r.want.b3 = BYTE_W'(e3);
    return r;
  endfunction

  // code point from a random range, biased toward the range edges and the values just outside
  function automatic logic [CP_W-1:0] pick_cp();
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    k = $urandom_range(N_RNG - 1, 0);
    lo = RNG_CP_LO[k];
    hi = RNG_CP_HI[k];
    case ($urandom_range(7, 0))
      0: return CP_W'(lo - 1);
      1: return CP_W'(lo);
      2: return CP_W'(hi);
      3: return CP_W'(hi + 1);
      default: return CP_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic stim_t rand_beat();
    stim_t       s;
    conv_t       e;
    int unsigned sel;
    s = mk(OP_DECODE, $urandom, $urandom, $urandom, $urandom, $urandom);
    sel = $urandom_range(99, 0);
    if (sel < 35) begin
      s.op = OP_ENCODE;
      s.cp = pick_cp();
    end else if (sel < 45) begin
      s.op = OP_ENCODE;
    end else if (sel < 80) begin
      e = gb_convert(OP_ENCODE, pick_cp(), '0, '0, '0, '0);
      if (e.status == STATUS_OK) begin
        s.b0 = e.b0;
        s.b1 = e.b1;
        s.b2 = e.b2;
        s.b3 = e.b3;
      end
    end else if (sel < 90) begin
      s.b0 = BYTE_W'($urandom_range(LEAD_HI, LEAD_LO));
      s.b1 = BYTE_W'($urandom_range(TRAIL_HI, TRAIL_LO));
      s.b2 = BYTE_W'($urandom_range(LEAD_HI, LEAD_LO));
      s.b3 = BYTE_W'($urandom_range(TRAIL_HI, TRAIL_LO));
    end
    return s;
  endfunction

  task automatic send(input stim_t s);
    conv_t w;
    in_operation  <= s.op;
    in_code_point <= s.cp;
    in_byte_0     <= s.b0;
    in_byte_1     <= s.b1;
    in_byte_2     <= s.b2;
    in_byte_3     <= s.b3;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    w = s.typed ? s.want : gb_convert(s.op, s.cp, s.b0, s.b1, s.b2, s.b3);
    conv_due.push_back(w);
    if (s.op == OP_ENCODE) n_enc++;
    else n_dec++;
    if (w.status == STATUS_ILLEGAL) n_ill++;
  endtask

  task automatic hold(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (conv_due.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    conv_t w;
    if (rst_n && out_valid === 1'b1) begin
      if (conv_due.size() == 0) begin
        $error("unexpected result beat: out_status %0d", out_status);
        n_err++;
      end else begin
        w = conv_due.pop_front();
        n_checked++;
        if (out_status !== w.status) begin
          $error("out_status: expected %0d, got %0d", w.status, out_status);
          n_err++;
        end
        if (out_code_point !== w.cp) begin
          $error("out_code_point: expected %06h, got %06h", w.cp, out_code_point);
          n_err++;
        end
        if (out_byte_0 !== w.b0) begin
          $error("out_byte_0: expected %02h, got %02h", w.b0, out_byte_0);
          n_err++;
        end
        if (out_byte_1 !== w.b1) begin
          $error("out_byte_1: expected %02h, got %02h", w.b1, out_byte_1);
          n_err++;
        end
        if (out_byte_2 !== w.b2) begin
          $error("out_byte_2: expected %02h, got %02h", w.b2, out_byte_2);
          n_err++;
        end
        if (out_byte_3 !== w.b3) begin
          $error("out_byte_3: expected %02h, got %02h", w.b3, out_byte_3);
          n_err++;
        end
      end
    end
  end

  // watchdog: cycles without any beat on either side
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int gap_pct;
    gap_pct = 20;

    // encode: out of range, range edges, known mappings; byte inputs are don't-care
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h000000, 'hff, 'hff, 'hff, 'hff),
                            STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h1fffff, 'h90, 'h30, 'h81, 'h30),
                            STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h110000, 0, 0, 0, 0), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h000451, 0, 0, 0, 0), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h00d800, 0, 0, 0, 0), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h000452, 0, 0, 0, 0), STATUS_OK, 0, 'h81, 'h30, 'hd3, 'h30));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h00ffff, 0, 0, 0, 0), STATUS_OK, 0, 'h84, 'h31, 'ha4, 'h39));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h010000, 0, 0, 0, 0), STATUS_OK, 0, 'h90, 'h30, 'h81, 'h30));
    dir_tab.push_back(typed(mk(OP_ENCODE, 'h10ffff, 0, 0, 0, 0), STATUS_OK, 0, 'he3, 'h32, 'h9a, 'h35));
    dir_tab.push_back(mk(OP_ENCODE, 'h00200f, 'h55, 'haa, 'h55, 'haa));
    dir_tab.push_back(mk(OP_ENCODE, 'h002e80, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_ENCODE, 'h00d7ff, 0, 0, 0, 0));
    // decode: known mappings, just past the last range and in other gaps, malformed bytes
    dir_tab.push_back(typed(mk(OP_DECODE, 'h1fffff, 'h81, 'h30, 'hd3, 'h30),
                            STATUS_OK, 'h000452, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h84, 'h31, 'ha4, 'h39), STATUS_OK, 'h00ffff, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h90, 'h30, 'h81, 'h30), STATUS_OK, 'h010000, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'he3, 'h32, 'h9a, 'h35), STATUS_OK, 'h10ffff, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'he3, 'h32, 'h9a, 'h36), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h84, 'h31, 'ha5, 'h30), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h81, 'h30, 'h81, 'h30), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'hfe, 'h39, 'hfe, 'h39), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h80, 'h30, 'h81, 'h30), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'hff, 'h30, 'h81, 'h30), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h90, 'h2f, 'h81, 'h30), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h90, 'h30, 'h80, 'h30), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(typed(mk(OP_DECODE, 0, 'h90, 'h30, 'h81, 'h3a), STATUS_ILLEGAL, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_DECODE, 'h0abcde, 'h82, 'h35, 'h8f, 'h39));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if ($urandom_range(99, 0) < gap_pct) hold($urandom_range(17, 1));
      send(dir_tab[i]);
    end
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) gap_pct = $urandom_range(2, 0) * 15;
      if (n == N_RANDOM / 2) drain();
      if (n < N_RANDOM - N_QUIET && $urandom_range(99, 0) < gap_pct) hold($urandom_range(17, 1));
      send(rand_beat());
    end
    start <= 1'b0;

    while (conv_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d beats in (%0d encode, %0d decode, %0d illegal), %0d results checked",
             n_enc + n_dec, n_enc, n_dec, n_ill, n_checked);
    $display("range edges, malformed lead and trail bytes, idle bursts and a full drain mid-run");
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gbfr_pkg.sv
rtl/gbfr_classify.sv
rtl/gbfr_linear.sv
rtl/gbfr_divide.sv
rtl/gbfr_emit.sv
rtl/gb18030_four_byte_range_codec_unit.sv
tb/gb18030_four_byte_range_codec_unit_tb.sv
